/* hw/rtl/bbe_pkg.sv */
// Package for the B-spline basis evaluator: sizes, constants, payload types,
// state encodings and the 48-bit saturation helper.
// Depends on nothing; every RTL file of the block refers to it by scoped names.
`default_nettype none

package bbe_pkg;

  localparam int MAX_ORDER  = 4;
  localparam int KNOT_DEPTH = 64;
  localparam int KNOT_W     = 32;
  localparam int VAL_W      = 48;
  localparam int KNOT_AW    = $clog2(KNOT_DEPTH);
  localparam int CNT_W      = $clog2(KNOT_DEPTH + 1);
  localparam int ORD_W      = $clog2(MAX_ORDER + 1);
  localparam int SPAN_W     = KNOT_AW + 2;
  localparam int MD_AW      = VAL_W + 1 + ORD_W;
  localparam int MD_BW      = KNOT_W + 1;
  localparam int MD_PW      = MD_AW + MD_BW;
  localparam int MD_CW      = $clog2(MD_PW + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [2:0] ORDER_RESET = 3'd4;
  localparam logic [6:0] KNOTS_RESET = 7'd64;

  localparam logic signed [VAL_W-1:0] SAT_HI  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SAT_LO  = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] ONE_Q32 = 48'sh0001_0000_0000;
  localparam logic signed [MD_BW-1:0] DIFF_SCALE = 33'sd65536;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORDER = 1'b0,
    REG_KNOTS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                     command;
    logic [5:0]               knot_index;
    logic signed [KNOT_W-1:0] knot_value;
    logic signed [KNOT_W-1:0] x_value;
    logic [1:0]               deriv_order;
  } req_t;

  typedef struct packed {
    logic signed [6:0]       basis_offset;
    logic signed [VAL_W-1:0] basis_value;
    logic                    out_of_range;
    logic                    last_of_run;
  } res_t;

  typedef struct packed {
    logic                    start;
    logic signed [MD_AW-1:0] a;
    logic signed [MD_BW-1:0] b;
    logic signed [MD_BW-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] q;
  } md_rsp_t;

  typedef enum logic [1:0] {
    PH_VAL,
    PH_DIFF,
    PH_SMOOTH
  } phase_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_FIN
  } md_state_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_EDGE_RD,
    ST_EDGE_CMP,
    ST_PLAN,
    ST_INIT_D,
    ST_FETCH_P,
    ST_FETCH_Q,
    ST_GET_A,
    ST_GET_B,
    ST_MD1,
    ST_MD1_W,
    ST_MD2,
    ST_MD2_W,
    ST_WRITE,
    ST_SETLAST,
    ST_EMIT,
    ST_EMIT_W
  } top_state_t;

  function automatic logic signed [VAL_W-1:0] sat48(input logic signed [VAL_W:0] v);
    logic signed [VAL_W-1:0] r;
    if (v[VAL_W] != v[VAL_W-1]) begin
      r = v[VAL_W] ? SAT_LO : SAT_HI;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bbe_knot_ram.sv */
// Knot table of the B-spline basis evaluator: one write port, one registered
// read port. Depends on bbe_pkg for depth and width.
`default_nettype none

module bbe_knot_ram (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [bbe_pkg::KNOT_AW-1:0]           waddr,
  input  logic signed [bbe_pkg::KNOT_W-1:0]     wdata,
  input  logic [bbe_pkg::KNOT_AW-1:0]           raddr,
  output logic signed [bbe_pkg::KNOT_W-1:0]     rdata
);

  logic signed [bbe_pkg::KNOT_W-1:0] mem [bbe_pkg::KNOT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/bbe_muldiv.sv */
// Shared product-quotient unit: a*b/d truncated toward zero and saturated to
// 48 bits, by shift-add multiply then restoring division. Depends on bbe_pkg.
`default_nettype none

module bbe_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  bbe_pkg::md_req_t  md_req,
  output bbe_pkg::md_rsp_t  md_rsp
);

  bbe_pkg::md_state_t state;

  logic [bbe_pkg::MD_PW-1:0] acc;
  logic [bbe_pkg::MD_PW-1:0] mshift;
  logic [bbe_pkg::MD_BW-1:0] mb;
  logic [bbe_pkg::MD_BW-1:0] ud;
  logic [bbe_pkg::MD_BW:0]   rem;
  logic [bbe_pkg::MD_CW-1:0] cnt;
  logic                      neg;
  logic                      done;
  logic signed [bbe_pkg::VAL_W-1:0] q_out;

  logic [bbe_pkg::MD_AW-1:0] mag_a;
  logic [bbe_pkg::MD_BW-1:0] mag_b;
  logic [bbe_pkg::MD_BW-1:0] mag_d;
  logic [bbe_pkg::MD_BW:0]   rem_sh;
  logic                      qbit;
  logic                      trivial;

  always_comb begin
    mag_a   = md_req.a[bbe_pkg::MD_AW-1] ? -md_req.a : md_req.a;
    mag_b   = md_req.b[bbe_pkg::MD_BW-1] ? -md_req.b : md_req.b;
    mag_d   = md_req.d[bbe_pkg::MD_BW-1] ? -md_req.d : md_req.d;
    trivial = (md_req.a == '0) || (md_req.b == '0) || (md_req.d == '0);
    rem_sh  = {rem[bbe_pkg::MD_BW-1:0], acc[bbe_pkg::MD_PW-1]};
    qbit    = (rem_sh >= {1'b0, ud});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbe_pkg::MD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        bbe_pkg::MD_IDLE: begin
          if (md_req.start) begin
            if (trivial) begin
              done <= 1'b1;
            end else begin
              state <= bbe_pkg::MD_MUL;
            end
          end
        end
        bbe_pkg::MD_MUL: begin
          if (cnt == bbe_pkg::MD_CW'(bbe_pkg::MD_BW - 1)) begin
            state <= bbe_pkg::MD_DIV;
          end
        end
        bbe_pkg::MD_DIV: begin
          if (cnt == bbe_pkg::MD_CW'(bbe_pkg::MD_PW - 1)) begin
            state <= bbe_pkg::MD_FIN;
          end
        end
        bbe_pkg::MD_FIN: begin
          state <= bbe_pkg::MD_IDLE;
          done  <= 1'b1;
        end
        default: state <= bbe_pkg::MD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bbe_pkg::MD_IDLE: begin
        if (md_req.start) begin
          acc    <= '0;
          mshift <= bbe_pkg::MD_PW'(mag_a);
          mb     <= mag_b;
          ud     <= mag_d;
          cnt    <= '0;
          neg    <= (md_req.a[bbe_pkg::MD_AW-1] ^ md_req.b[bbe_pkg::MD_BW-1])
                    ^ md_req.d[bbe_pkg::MD_BW-1];
          q_out  <= '0;
        end
      end
      bbe_pkg::MD_MUL: begin
        if (mb[0]) begin
          acc <= acc + mshift;
        end
        mshift <= mshift << 1;
        mb     <= mb >> 1;
        if (cnt == bbe_pkg::MD_CW'(bbe_pkg::MD_BW - 1)) begin
          cnt <= '0;
          rem <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      bbe_pkg::MD_DIV: begin
        rem <= qbit ? (rem_sh - {1'b0, ud}) : rem_sh;
        acc <= {acc[bbe_pkg::MD_PW-2:0], qbit};
        cnt <= cnt + 1'b1;
      end
      bbe_pkg::MD_FIN: begin
        if (neg) begin
          if (acc >= (bbe_pkg::MD_PW'(1) << (bbe_pkg::VAL_W - 1))) begin
            q_out <= bbe_pkg::SAT_LO;
          end else begin
            q_out <= -$signed(acc[bbe_pkg::VAL_W-1:0]);
          end
        end else begin
          if (acc > bbe_pkg::MD_PW'(bbe_pkg::SAT_HI)) begin
            q_out <= bbe_pkg::SAT_HI;
          end else begin
            q_out <= acc[bbe_pkg::VAL_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign md_rsp.done = done;
  assign md_rsp.q    = q_out;

endmodule

`default_nettype wire

/* hw/rtl/bspline_basis_evaluator.sv */
// Top level of the B-spline basis evaluator: sequencer, span search and the
// Cox-de Boor and differencing loops around one shared product-quotient unit.
// Depends on bbe_pkg, bbe_knot_ram and bbe_muldiv.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_data (bbe_pkg::req_t)
//   res      out        res_valid/res_ready    res_data (bbe_pkg::res_t)
//   cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A knot load is written to the table as it is accepted. An evaluate request
// scans the knot table through a read and a compare state per knot, then runs
// every product-quotient through the shared unit: two per Cox-de Boor step,
// order*(order-1)/2 steps for values, and for derivatives one per differencing
// step and two per smoothing step, for every basis function in turn.
// Each result waits in the output register until taken; the block then goes on.
// Reset is synchronous; it restores order 4 and 64 knots and leaves the table.
`default_nettype none

module bspline_basis_evaluator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  bbe_pkg::req_t                       req_data,
  output logic                                res_valid,
  input  logic                                res_ready,
  output bbe_pkg::res_t                       res_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bbe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bbe_pkg::top_state_t state, state_next;
  bbe_pkg::phase_t     phase;

  logic [2:0] spline_order;
  logic [6:0] knot_count;

  logic signed [bbe_pkg::KNOT_W-1:0] x;
  logic [1:0]                        dord;
  logic signed [bbe_pkg::SPAN_W-1:0] s;
  logic [bbe_pkg::KNOT_AW-1:0]       sidx;
  logic                              at_edge;
  logic [bbe_pkg::ORD_W-1:0]         i, j, k, dl;
  logic signed [bbe_pkg::KNOT_W-1:0] kp, kq;
  logic signed [bbe_pkg::VAL_W-1:0]  ca, cb, t1, t2, keep;
  logic signed [bbe_pkg::VAL_W-1:0]  c [bbe_pkg::MAX_ORDER + 1];

  logic                              ram_we;
  logic [bbe_pkg::KNOT_AW-1:0]       ram_raddr;
  logic signed [bbe_pkg::KNOT_W-1:0] ram_rdata;

  bbe_pkg::md_req_t md_req;
  bbe_pkg::md_rsp_t md_rsp;

  logic [bbe_pkg::ORD_W-1:0]         ord, deg, cidx;
  logic [bbe_pkg::CNT_W-1:0]         nk;
  logic signed [bbe_pkg::SPAN_W-1:0] last, p_idx, q_idx;
  logic                              eval_acc, scan_stop, span_bad, deriv_zero, last_k;
  logic signed [bbe_pkg::VAL_W-1:0]  c_rd, emit_val;
  logic signed [bbe_pkg::VAL_W:0]    cdiff;
  logic signed [bbe_pkg::MD_AW:0]    cscaled;
  logic signed [bbe_pkg::MD_BW-1:0]  kp_x, x_q, den;
  logic signed [bbe_pkg::MD_AW-1:0]  ca_ext, cb_ext;

  bbe_knot_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req_data.knot_index[bbe_pkg::KNOT_AW-1:0]),
    .wdata (req_data.knot_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bbe_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .md_req (md_req),
    .md_rsp (md_rsp)
  );

  always_comb begin
    if (spline_order == 3'd0) begin
      ord = bbe_pkg::ORD_W'(1);
    end else if (32'(spline_order) > bbe_pkg::MAX_ORDER) begin
      ord = bbe_pkg::ORD_W'(bbe_pkg::MAX_ORDER);
    end else begin
      ord = bbe_pkg::ORD_W'(spline_order);
    end
    if (knot_count == 7'd0) begin
      nk = bbe_pkg::CNT_W'(1);
    end else if (32'(knot_count) > bbe_pkg::KNOT_DEPTH) begin
      nk = bbe_pkg::CNT_W'(bbe_pkg::KNOT_DEPTH);
    end else begin
      nk = bbe_pkg::CNT_W'(knot_count);
    end
    deg        = ord - 1'b1;
    last       = $signed(bbe_pkg::SPAN_W'(nk)) - $signed(bbe_pkg::SPAN_W'(ord));
    p_idx      = s + $signed(bbe_pkg::SPAN_W'(k));
    q_idx      = p_idx - $signed(bbe_pkg::SPAN_W'(j));
    eval_acc   = req_valid && req_ready && (req_data.command == bbe_pkg::CMD_EVAL);
    ram_we     = req_valid && req_ready && (req_data.command == bbe_pkg::CMD_LOAD);
    scan_stop  = (ram_rdata > x) || (bbe_pkg::CNT_W'(sidx) == nk - 1'b1);
    span_bad   = (s < $signed(bbe_pkg::SPAN_W'(ord))) || (s > last);
    deriv_zero = (bbe_pkg::ORD_W'(dord) > deg) || (at_edge && bbe_pkg::ORD_W'(dord) == deg);
    last_k     = (k == j - 1'b1);
    kp_x       = {kp[bbe_pkg::KNOT_W-1], kp} - {x[bbe_pkg::KNOT_W-1], x};
    x_q        = {x[bbe_pkg::KNOT_W-1], x} - {kq[bbe_pkg::KNOT_W-1], kq};
    den        = {kp[bbe_pkg::KNOT_W-1], kp} - {kq[bbe_pkg::KNOT_W-1], kq};
    ca_ext     = {{(bbe_pkg::MD_AW - bbe_pkg::VAL_W){ca[bbe_pkg::VAL_W-1]}}, ca};
    cb_ext     = {{(bbe_pkg::MD_AW - bbe_pkg::VAL_W){cb[bbe_pkg::VAL_W-1]}}, cb};
    cdiff      = {cb[bbe_pkg::VAL_W-1], cb} - {ca[bbe_pkg::VAL_W-1], ca};
    cscaled    = cdiff * $signed({1'b0, j});
  end

  always_comb begin
    state_next   = state;
    ram_raddr    = sidx;
    cidx         = k;
    md_req.start = 1'b0;
    if (state == bbe_pkg::ST_MD2) begin
      md_req.a = (phase == bbe_pkg::PH_SMOOTH) ? cb_ext : ca_ext;
      md_req.b = x_q;
    end else begin
      md_req.a = (phase == bbe_pkg::PH_DIFF) ? cscaled[bbe_pkg::MD_AW-1:0] : ca_ext;
      md_req.b = (phase == bbe_pkg::PH_DIFF) ? bbe_pkg::DIFF_SCALE : kp_x;
    end
    md_req.d = den;
    unique case (state)
      bbe_pkg::ST_IDLE: begin
        if (eval_acc) begin
          state_next = bbe_pkg::ST_SRCH_RD;
        end
      end
      bbe_pkg::ST_SRCH_RD: state_next = bbe_pkg::ST_SRCH_CMP;
      bbe_pkg::ST_SRCH_CMP: begin
        state_next = scan_stop ? bbe_pkg::ST_EDGE_RD : bbe_pkg::ST_SRCH_RD;
      end
      bbe_pkg::ST_EDGE_RD: begin
        ram_raddr = last[bbe_pkg::KNOT_AW-1:0];
        if (last >= 0 && s > last) begin
          state_next = bbe_pkg::ST_EDGE_CMP;
        end else begin
          state_next = bbe_pkg::ST_PLAN;
        end
      end
      bbe_pkg::ST_EDGE_CMP: state_next = bbe_pkg::ST_PLAN;
      bbe_pkg::ST_PLAN: begin
        if (span_bad) begin
          state_next = bbe_pkg::ST_EMIT;
        end else if (dord == 2'd0) begin
          state_next = (deg == '0) ? bbe_pkg::ST_EMIT : bbe_pkg::ST_FETCH_P;
        end else begin
          state_next = bbe_pkg::ST_INIT_D;
        end
      end
      bbe_pkg::ST_INIT_D: begin
        state_next = deriv_zero ? bbe_pkg::ST_EMIT : bbe_pkg::ST_FETCH_P;
      end
      bbe_pkg::ST_FETCH_P: begin
        ram_raddr  = p_idx[bbe_pkg::KNOT_AW-1:0];
        state_next = bbe_pkg::ST_FETCH_Q;
      end
      bbe_pkg::ST_FETCH_Q: begin
        ram_raddr  = q_idx[bbe_pkg::KNOT_AW-1:0];
        state_next = bbe_pkg::ST_GET_A;
      end
      bbe_pkg::ST_GET_A: state_next = bbe_pkg::ST_GET_B;
      bbe_pkg::ST_GET_B: begin
        cidx       = k + 1'b1;
        state_next = bbe_pkg::ST_MD1;
      end
      bbe_pkg::ST_MD1: begin
        md_req.start = 1'b1;
        state_next   = bbe_pkg::ST_MD1_W;
      end
      bbe_pkg::ST_MD1_W: begin
        if (md_rsp.done) begin
          state_next = (phase == bbe_pkg::PH_DIFF) ? bbe_pkg::ST_WRITE : bbe_pkg::ST_MD2;
        end
      end
      bbe_pkg::ST_MD2: begin
        md_req.start = 1'b1;
        state_next   = bbe_pkg::ST_MD2_W;
      end
      bbe_pkg::ST_MD2_W: begin
        if (md_rsp.done) begin
          state_next = bbe_pkg::ST_WRITE;
        end
      end
      bbe_pkg::ST_WRITE: begin
        state_next = bbe_pkg::ST_FETCH_P;
        if (last_k) begin
          if (phase == bbe_pkg::PH_VAL) begin
            state_next = bbe_pkg::ST_SETLAST;
          end else if (j == bbe_pkg::ORD_W'(1)) begin
            if (phase == bbe_pkg::PH_SMOOTH || dl == bbe_pkg::ORD_W'(1)) begin
              state_next = bbe_pkg::ST_EMIT;
            end
          end
        end
      end
      bbe_pkg::ST_SETLAST: begin
        state_next = (j == deg) ? bbe_pkg::ST_EMIT : bbe_pkg::ST_FETCH_P;
      end
      bbe_pkg::ST_EMIT: begin
        cidx       = (dord == 2'd0) ? i : '0;
        state_next = bbe_pkg::ST_EMIT_W;
      end
      bbe_pkg::ST_EMIT_W: begin
        if (res_ready) begin
          if (i == deg) begin
            state_next = bbe_pkg::ST_IDLE;
          end else if (!span_bad && dord != 2'd0) begin
            state_next = bbe_pkg::ST_INIT_D;
          end else begin
            state_next = bbe_pkg::ST_EMIT;
          end
        end
      end
      default: state_next = bbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    c_rd = c[cidx];
    if (span_bad) begin
      emit_val = bbe_pkg::SAT_HI;
    end else if (dord != 2'd0 && deriv_zero) begin
      emit_val = '0;
    end else begin
      emit_val = c_rd;
    end
  end

  assign req_ready = (state == bbe_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bbe_pkg::ST_IDLE;
      spline_order <= bbe_pkg::ORDER_RESET;
      knot_count   <= bbe_pkg::KNOTS_RESET;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bbe_pkg::REG_ORDER: spline_order <= cfg_data[2:0];
          bbe_pkg::REG_KNOTS: knot_count   <= cfg_data;
          default: ;
        endcase
      end
      if (state == bbe_pkg::ST_EMIT) begin
        res_valid <= 1'b1;
      end else if (state == bbe_pkg::ST_EMIT_W && res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bbe_pkg::ST_IDLE: begin
        if (eval_acc) begin
          x       <= req_data.x_value;
          dord    <= req_data.deriv_order;
          s       <= '1;
          sidx    <= '0;
          at_edge <= 1'b0;
        end
      end
      bbe_pkg::ST_SRCH_CMP: begin
        if (ram_rdata >= x) begin
          s <= $signed(bbe_pkg::SPAN_W'(sidx));
        end
        if (!scan_stop) begin
          sidx <= sidx + 1'b1;
        end
      end
      bbe_pkg::ST_EDGE_CMP: begin
        if (ram_rdata == x) begin
          at_edge <= 1'b1;
          s       <= last;
        end
      end
      bbe_pkg::ST_PLAN: begin
        i     <= '0;
        j     <= bbe_pkg::ORD_W'(1);
        k     <= '0;
        keep  <= '0;
        phase <= bbe_pkg::PH_VAL;
        c[0]  <= bbe_pkg::ONE_Q32;
      end
      bbe_pkg::ST_INIT_D: begin
        for (int n = 0; n <= bbe_pkg::MAX_ORDER; n++) begin
          c[n] <= (bbe_pkg::ORD_W'(n) == i) ? bbe_pkg::ONE_Q32 : '0;
        end
        j     <= deg;
        k     <= '0;
        dl    <= bbe_pkg::ORD_W'(dord);
        phase <= bbe_pkg::PH_DIFF;
      end
      bbe_pkg::ST_FETCH_Q: kp <= ram_rdata;
      bbe_pkg::ST_GET_A: begin
        kq <= ram_rdata;
        ca <= c_rd;
      end
      bbe_pkg::ST_GET_B: cb <= c_rd;
      bbe_pkg::ST_MD1_W: begin
        if (md_rsp.done) begin
          t1 <= md_rsp.q;
        end
      end
      bbe_pkg::ST_MD2_W: begin
        if (md_rsp.done) begin
          t2 <= md_rsp.q;
        end
      end
      bbe_pkg::ST_WRITE: begin
        case (phase)
          bbe_pkg::PH_VAL: begin
            c[k] <= bbe_pkg::sat48({keep[bbe_pkg::VAL_W-1], keep} + {t1[bbe_pkg::VAL_W-1], t1});
            keep <= t2;
            if (!last_k) begin
              k <= k + 1'b1;
            end
          end
          bbe_pkg::PH_SMOOTH: begin
            c[k] <= bbe_pkg::sat48({t1[bbe_pkg::VAL_W-1], t1} + {t2[bbe_pkg::VAL_W-1], t2});
            if (last_k) begin
              j <= j - 1'b1;
              k <= '0;
            end else begin
              k <= k + 1'b1;
            end
          end
          default: begin
            c[k] <= t1;
            if (last_k) begin
              j  <= j - 1'b1;
              k  <= '0;
              dl <= dl - 1'b1;
              if (dl == bbe_pkg::ORD_W'(1)) begin
                phase <= bbe_pkg::PH_SMOOTH;
              end
            end else begin
              k <= k + 1'b1;
            end
          end
        endcase
      end
      bbe_pkg::ST_SETLAST: begin
        c[j] <= keep;
        keep <= '0;
        j    <= j + 1'b1;
        k    <= '0;
      end
      bbe_pkg::ST_EMIT: begin
        res_data.basis_offset <= 7'(s - $signed(bbe_pkg::SPAN_W'(ord)));
        res_data.basis_value  <= emit_val;
        res_data.out_of_range <= span_bad;
        res_data.last_of_run  <= (i == deg);
      end
      bbe_pkg::ST_EMIT_W: begin
        if (res_ready) begin
          i <= i + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // The shared unit only answers while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> (state == bbe_pkg::ST_MD1_W || state == bbe_pkg::ST_MD2_W))
    else $error("product-quotient finished outside a wait state");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !res_valid)
    else $error("request taken while a result is pending");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_data.last_of_run |=> state == bbe_pkg::ST_IDLE)
    else $error("run did not end after its last result");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == bbe_pkg::ST_EMIT)
    else $error("result raised outside the emit step");

endmodule

`default_nettype wire

/* test/bspline_basis_evaluator_test.sv */
// Self-checking testbench for bspline_basis_evaluator: loads knot tables, sweeps
// configurations and evaluation points, and checks every result against a predictor.
// Depends on bbe_pkg and the block's RTL.
module bspline_basis_evaluator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SATH = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SATL = -64'sh0000_8000_0000_0000;
  localparam longint ONE = 64'sh0000_0001_0000_0000;
  localparam int LIMIT = 12_000_000;
  localparam int QUIET_LO = 30_000;
  localparam int QUIET_HI = 70_000;
  localparam int HOLD_AT = 5_000;
  localparam int HOLD_LEN = 6_000;
  localparam int PH_ORD[10] = '{4, 1, 2, 3, 4, 0, 7, 2, 4, 3};
  localparam int PH_CNT[10] = '{64, 8, 16, 20, 64, 0, 127, 5, 9, 12};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  bbe_pkg::req_t req_data = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  bbe_pkg::res_t res_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bbe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bbe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bbe_pkg::req_t req_backlog[$];
  bbe_pkg::res_t basis_due[$];
  longint knots[64];
  longint plan[64];
  int order_reg = 4;
  int count_reg = 64;
  int errors = 0;
  int cyc = 0;
  logic req_fire = 1'b0;

  bspline_basis_evaluator u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint sat48(longint v);
    if (v > SATH) return SATH;
    if (v < SATL) return SATL;
    return v;
  endfunction

  function automatic longint prod_quot(longint a, longint b, longint d);
    logic signed [127:0] p;
    if (d == 0 || a == 0 || b == 0) return 0;
    p = (128'(a) * 128'(b)) / 128'(d);
    if (p > 128'(SATH)) return SATH;
    if (p < 128'(SATL)) return SATL;
    return longint'(p);
  endfunction

  function automatic longint knot_at(int i);
    if (i < 0 || i > 63) return 0;
    return knots[i];
  endfunction

  task automatic predict_basis(longint x, int d);
    longint vals[4];
    longint a[5];
    longint rd[4];
    longint ld[4];
    longint keep, den, nb;
    int ord, nk, s, last, deg, dd, outer, i, j, r, k, m;
    bit on_boundary, oor;
    bbe_pkg::res_t e;
    ord = order_reg < 1 ? 1 :
          (order_reg > bbe_pkg::MAX_ORDER ? bbe_pkg::MAX_ORDER : order_reg);
    nk = count_reg < 1 ? 1 :
         (count_reg > bbe_pkg::KNOT_DEPTH ? bbe_pkg::KNOT_DEPTH : count_reg);
    s = -1;
    for (i = 0; i < nk; i++) begin
      if (knots[i] >= x) s = i;
      if (knots[i] > x) break;
    end
    last = nk - ord;
    on_boundary = 0;
    if (last >= 0 && s > last && knots[last] == x) begin
      on_boundary = 1;
      s = last;
    end
    oor = (s < ord || s > last);
    deg = ord - 1;
    if (oor) begin
      for (i = 0; i < ord; i++) vals[i] = SATH;
    end else if (d == 0) begin
      for (m = 0; m < deg; m++) begin
        rd[m] = knot_at(s + m) - x;
        ld[m] = x - knot_at(s - m - 1);
      end
      vals[0] = ONE;
      for (j = 1; j <= deg; j++) begin
        keep = 0;
        for (r = 0; r < j; r++) begin
          den = rd[r] + ld[j-1-r];
          nb = sat48(keep + prod_quot(vals[r], rd[r], den));
          keep = prod_quot(vals[r], ld[j-1-r], den);
          vals[r] = nb;
        end
        vals[j] = keep;
      end
    end else begin
      for (i = 0; i < ord; i++) begin
        for (j = 0; j < 5; j++) a[j] = 0;
        a[i] = ONE;
        if (d > deg || (on_boundary && d == deg)) begin
          vals[i] = 0;
        end else begin
          dd = d;
          outer = deg;
          while (dd > 0) begin
            for (k = 0; k < outer; k++) begin
              den = knot_at(s + k) - knot_at(s + k - outer);
              a[k] = prod_quot(longint'(outer) * (a[k+1] - a[k]), 65536, den);
            end
            outer--;
            dd--;
          end
          for (m = 0; m < outer; m++) begin
            rd[m] = knot_at(s + m) - x;
            ld[m] = x - knot_at(s - m - 1);
          end
          while (outer > 0) begin
            outer--;
            for (k = 0; k <= outer; k++) begin
              den = rd[k] + ld[outer-k];
              a[k] = sat48(prod_quot(a[k+1], ld[outer-k], den) + prod_quot(a[k], rd[k], den));
            end
          end
          vals[i] = sat48(a[0]);
        end
      end
    end
    for (i = 0; i < ord; i++) begin
      e.basis_offset = 7'(s - ord);
      e.basis_value = 48'(vals[i]);
      e.out_of_range = oor;
      e.last_of_run = (i == ord - 1);
      basis_due.push_back(e);
    end
  endtask

  task automatic report(string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cyc, msg);
  endtask

  always @(posedge clk) begin : watch
    bbe_pkg::res_t e;
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      req_fire <= !rst && req_valid && req_ready;
      if (!rst && req_valid && req_ready) begin
        if (req_data.command == bbe_pkg::CMD_EVAL) begin
          predict_basis(longint'(req_data.x_value), int'(req_data.deriv_order));
        end else begin
          knots[req_data.knot_index] = longint'(req_data.knot_value);
        end
      end
      if (!rst && res_valid && res_ready) begin
        if (basis_due.size() == 0) begin
          report("result with nothing expected");
        end else begin
          e = basis_due.pop_front();
          if (res_data.basis_offset !== e.basis_offset)
            report($sformatf("offset %0d, expected %0d", res_data.basis_offset, e.basis_offset));
          if (res_data.basis_value !== e.basis_value)
            report($sformatf("value %h, expected %h", res_data.basis_value, e.basis_value));
          if (res_data.out_of_range !== e.out_of_range)
            report($sformatf("out_of_range %b, expected %b", res_data.out_of_range,
                             e.out_of_range));
          if (res_data.last_of_run !== e.last_of_run)
            report($sformatf("last_of_run %b, expected %b", res_data.last_of_run,
                             e.last_of_run));
        end
      end
    end
  end

  always @(negedge clk) begin : drive_req
    bbe_pkg::req_t nxt;
    logic v;
    bit quiet;
    v = req_valid;
    nxt = req_data;
    quiet = (cyc >= QUIET_LO && cyc < QUIET_HI);
    if (rst) begin
      v = 1'b0;
    end else if (!req_valid || req_fire) begin
      v = 1'b0;
      if (req_backlog.size() > 0 && (quiet || $urandom_range(99) >= 34)) begin
        v = 1'b1;
        nxt = req_backlog.pop_front();
      end
    end
    req_valid <= v;
    req_data <= nxt;
  end

  always @(negedge clk) begin : drive_res_ready
    int res_cyc;
    if (rst) begin
      res_cyc = 0;
      res_ready <= 1'b0;
    end else begin
      res_cyc++;
      if (res_cyc >= HOLD_AT && res_cyc < HOLD_AT + HOLD_LEN)
        res_ready <= 1'b0;
      else
        res_ready <= (cyc >= QUIET_LO && cyc < QUIET_HI) || $urandom_range(99) >= 34;
    end
  end

  task automatic add_load(int idx, longint v);
    bbe_pkg::req_t r;
    r = '0;
    r.command = bbe_pkg::CMD_LOAD;
    r.knot_index = 6'(idx);
    r.knot_value = 32'(v);
    r.x_value = $urandom;
    r.deriv_order = 2'($urandom);
    req_backlog.push_back(r);
    plan[idx] = longint'(r.knot_value);
  endtask

  task automatic add_eval(longint x, int d);
    bbe_pkg::req_t r;
    r = '0;
    r.command = bbe_pkg::CMD_EVAL;
    r.knot_index = 6'($urandom);
    r.knot_value = $urandom;
    r.x_value = (x > 64'sd2147483647) ? 32'sh7FFF_FFFF :
                (x < -64'sd2147483648) ? 32'sh8000_0000 : 32'(x);
    r.deriv_order = 2'(d);
    req_backlog.push_back(r);
  endtask

  task automatic wait_idle();
    while (req_backlog.size() > 0 || req_valid || basis_due.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(bbe_pkg::cfg_reg_t idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 7'(val);
    do @(posedge clk); while (!cfg_ready);
    if (idx == bbe_pkg::REG_ORDER) order_reg = val & 7;
    else count_reg = val & 127;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int p, i, n, ordE, nkE, lastE, r, gap;
    longint v, x;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < 64; i++) begin
      v = -64'sd2147483648 + longint'(i) * 64'sd68174084;
      if (i == 11) v = plan[10];
      if (i == 63) v = 64'sd2147483647;
      add_load(i, v);
    end
    add_eval(-64'sd2147483648, 0);
    add_eval(64'sd2147483647, 1);
    add_eval(plan[0] - 1, 0);
    for (i = 0; i < 4; i++) add_eval(plan[60], i);
    for (i = 0; i < 4; i++) add_eval(plan[30] + 123456, i);
    add_eval(plan[11], 1);
    add_eval(plan[5], 2);
    add_eval(plan[3], 3);

    for (p = 1; p < 10; p++) begin
      wait_idle();
      write_reg(bbe_pkg::REG_ORDER, PH_ORD[p]);
      write_reg(bbe_pkg::REG_KNOTS, PH_CNT[p]);
      ordE = PH_ORD[p] < 1 ? 1 :
             (PH_ORD[p] > bbe_pkg::MAX_ORDER ? bbe_pkg::MAX_ORDER : PH_ORD[p]);
      nkE = PH_CNT[p] < 1 ? 1 :
            (PH_CNT[p] > bbe_pkg::KNOT_DEPTH ? bbe_pkg::KNOT_DEPTH : PH_CNT[p]);
      lastE = nkE - ordE;
      v = longint'($urandom_range(400000)) - 200000;
      if (nkE <= 20) begin
        for (i = 0; i < nkE; i++) begin
          if (p == 8) begin
            add_load(i, longint'($signed($urandom)));
          end else begin
            add_load(i, v);
            v += ($urandom_range(99) < 15) ? 0 : $urandom_range(1, 200000);
          end
        end
      end
      n = 7;
      for (i = 0; i < n; i++) begin
        r = $urandom_range(99);
        if (r < 55) begin
          x = (nkE > 1) ? $urandom_range(nkE - 2) : 0;
          gap = (nkE > 1) ? int'(plan[x+1] - plan[x]) : 0;
          x = plan[x] + ((gap > 0) ? longint'($urandom_range(gap)) : 0);
        end else if (r < 70) begin
          x = plan[$urandom_range(nkE - 1)];
        end else if (r < 82) begin
          x = (lastE >= 0) ? plan[lastE] : plan[0];
        end else if (r < 90) begin
          x = ($urandom_range(1)) ? plan[0] - 1 : plan[nkE-1] + 1;
        end else begin
          x = longint'($signed($urandom));
        end
        add_eval(x, $urandom_range(3));
        if ($urandom_range(99) < 10) begin
          r = $urandom_range(nkE - 1);
          add_load(r, plan[r]);
        end
      end
    end

    wait_idle();
    if (errors == 0 && basis_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
